// ----- hdl/spa_pkg.sv -----
// Package for the sparse polynomial adder: opcodes, status codes, the
// controller/datapath command and status structs and the saturating adder.
// No dependencies.
package spa_pkg;

    localparam int MAX_TERMS_DEF = 16;
    localparam int COEF_W        = 16;
    localparam int EXP_W         = 16;
    localparam int SUM_W         = 32;

    typedef enum logic [1:0] {
        OP_INS_A = 2'd0,
        OP_INS_B = 2'd1,
        OP_EMIT  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic compare;
        logic update;
        logic step;
        logic flush;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tables_empty;
        logic out_free;
        logic step_needs_out;
    } t_dp_stat;

    // Returns {saturated, value}.
    function automatic logic [SUM_W:0] sat_add32(input logic signed [SUM_W-1:0] a,
                                                  input logic signed [SUM_W-1:0] b);
        logic signed [SUM_W:0] s;
        logic [SUM_W:0]        r;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            r = {1'b1, s[SUM_W], {(SUM_W-1){~s[SUM_W]}}};
        end else begin
            r = {1'b0, s[SUM_W-1:0]};
        end
        return r;
    endfunction

endpackage

// ----- hdl/spa_in_if.sv -----
// Input channel of the sparse polynomial adder: valid/ready and one item.
// Depends on spa_pkg.
interface spa_in_if import spa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic signed [COEF_W-1:0] coefficient;
    logic [EXP_W-1:0]         exponent;

    modport source (output valid, output opcode, output coefficient, output exponent,
                    input ready);
    modport sink   (input valid, input opcode, input coefficient, input exponent,
                    output ready);
endinterface

// ----- hdl/spa_out_if.sv -----
// Result channel of the sparse polynomial adder: valid/ready and one result.
// Depends on spa_pkg.
interface spa_out_if import spa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] sum_coefficient;
    logic [EXP_W-1:0]        sum_exponent;
    logic                    last_term;
    logic                    empty_sum;
    logic [1:0]              status;

    modport source (output valid, output sum_coefficient, output sum_exponent,
                    output last_term, output empty_sum, output status, input ready);
    modport sink   (input valid, input sum_coefficient, input sum_exponent,
                    input last_term, input empty_sum, input status, output ready);
endinterface

// ----- hdl/spa_datapath.sv -----
// Datapath of the sparse polynomial adder: both term tables, the insert
// compare/update logic, the merge head, the held term and the output register.
// Depends on spa_pkg.
module spa_datapath import spa_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic [1:0]               i_opcode,
    input  logic signed [COEF_W-1:0] i_coefficient,
    input  logic [EXP_W-1:0]         i_exponent,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [SUM_W-1:0]  o_sum_coefficient,
    output logic [EXP_W-1:0]         o_sum_exponent,
    output logic                     o_last_term,
    output logic                     o_empty_sum,
    output logic [1:0]               o_status
);

    localparam int CW = $clog2(MAX_TERMS + 1);

    typedef logic [EXP_W-1:0]        t_ex_arr [MAX_TERMS];
    typedef logic signed [SUM_W-1:0] t_co_arr [MAX_TERMS];

    // Term tables; entries at or above the count are never read.
    t_ex_arr r_ex_a, n_ex_a, r_ex_b, n_ex_b;
    t_co_arr r_co_a, n_co_a, r_co_b, n_co_b;
    logic [CW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;

    // Latched insert item and compare results.
    logic                     r_sel;
    logic signed [COEF_W-1:0] r_coef;
    logic [EXP_W-1:0]         r_exp;
    logic [MAX_TERMS-1:0]     r_lt, r_eq;

    // Merged term held back until it is known whether it is the last one.
    logic                    r_held_v;
    logic signed [SUM_W-1:0] r_held_co;
    logic [EXP_W-1:0]        r_held_ex;
    logic [1:0]              r_held_st;

    logic                    r_out_v;
    logic signed [SUM_W-1:0] r_out_co;
    logic [EXP_W-1:0]        r_out_ex;
    logic                    r_out_last, r_out_empty;
    logic [1:0]              r_out_st;

    t_ex_arr              w_ex_sel, w_ex_up, w_ex_new, w_ex_dn_a, w_ex_dn_b;
    t_co_arr              w_co_sel, w_co_up, w_co_new, w_co_dn_a, w_co_dn_b;
    logic [CW-1:0]        w_cnt_sel;
    logic [MAX_TERMS-1:0] w_lt_prev;
    logic [MAX_TERMS-1:0] w_lt, w_eq;
    logic                 w_found, w_full;
    logic signed [SUM_W-1:0] w_match_co;
    logic [SUM_W:0]       w_ins_sum, w_mrg_sum;
    logic [1:0]           w_ins_st;
    logic                 w_ha, w_hb, w_take_a, w_take_b, w_both, w_produce;
    logic signed [SUM_W-1:0] w_term_co;
    logic [EXP_W-1:0]     w_term_ex;
    logic [1:0]           w_term_st;
    logic                 w_out_free, w_wr_out;

    always_comb begin
        if (r_sel) begin
            w_ex_sel = r_ex_b;
            w_co_sel = r_co_b;
        end else begin
            w_ex_sel = r_ex_a;
            w_co_sel = r_co_a;
        end
    end

    assign w_cnt_sel = r_sel ? r_cnt_b : r_cnt_a;

    // All entries are compared at once; the table is sorted so w_lt is a
    // thermometer code and w_eq has at most one bit set.
    always_comb begin
        for (int i = 0; i < MAX_TERMS; i++) begin
            w_lt[i] = (CW'(i) < w_cnt_sel) && (w_ex_sel[i] < r_exp);
            w_eq[i] = (CW'(i) < w_cnt_sel) && (w_ex_sel[i] == r_exp);
        end
    end

    always_comb begin
        w_lt_prev[0] = 1'b1;
        for (int i = 1; i < MAX_TERMS; i++) begin
            w_lt_prev[i] = r_lt[i-1];
        end
    end

    assign w_found   = |r_eq;
    assign w_full    = (w_cnt_sel == CW'(MAX_TERMS));

    always_comb begin
        w_match_co = '0;
        for (int i = 0; i < MAX_TERMS; i++) begin
            w_match_co = w_match_co | (r_eq[i] ? w_co_sel[i] : '0);
        end
    end

    assign w_ins_sum = sat_add32(w_match_co, SUM_W'(r_coef));

    always_comb begin
        if (w_found) begin
            w_ins_st = w_ins_sum[SUM_W] ? STAT_SAT : STAT_OK;
        end else if (w_full) begin
            w_ins_st = STAT_FULL;
        end else begin
            w_ins_st = STAT_OK;
        end
    end

    // Neighbour views of the tables: one place up for insert, one down for pop.
    always_comb begin
        w_ex_up[0] = w_ex_sel[0];
        w_co_up[0] = w_co_sel[0];
        for (int i = 1; i < MAX_TERMS; i++) begin
            w_ex_up[i] = w_ex_sel[i-1];
            w_co_up[i] = w_co_sel[i-1];
        end
        for (int i = 0; i < MAX_TERMS - 1; i++) begin
            w_ex_dn_a[i] = r_ex_a[i+1];
            w_co_dn_a[i] = r_co_a[i+1];
            w_ex_dn_b[i] = r_ex_b[i+1];
            w_co_dn_b[i] = r_co_b[i+1];
        end
        w_ex_dn_a[MAX_TERMS-1] = r_ex_a[MAX_TERMS-1];
        w_co_dn_a[MAX_TERMS-1] = r_co_a[MAX_TERMS-1];
        w_ex_dn_b[MAX_TERMS-1] = r_ex_b[MAX_TERMS-1];
        w_co_dn_b[MAX_TERMS-1] = r_co_b[MAX_TERMS-1];
    end

    // Updated selected table after an insert.
    always_comb begin
        w_ex_new = w_ex_sel;
        w_co_new = w_co_sel;
        for (int i = 0; i < MAX_TERMS; i++) begin
            if (w_found) begin
                if (r_eq[i]) begin
                    w_co_new[i] = w_ins_sum[SUM_W-1:0];
                end
            end else if (!r_lt[i]) begin
                if (w_lt_prev[i]) begin
                    w_ex_new[i] = r_exp;
                    w_co_new[i] = SUM_W'(r_coef);
                end else begin
                    w_ex_new[i] = w_ex_up[i];
                    w_co_new[i] = w_co_up[i];
                end
            end
        end
    end

    // Merge head.
    assign w_ha      = (r_cnt_a != '0);
    assign w_hb      = (r_cnt_b != '0);
    assign w_take_a  = w_ha && (!w_hb || (r_ex_a[0] < r_ex_b[0]));
    assign w_take_b  = w_hb && (!w_ha || (r_ex_b[0] < r_ex_a[0]));
    assign w_both    = w_ha && w_hb && (r_ex_a[0] == r_ex_b[0]);
    assign w_mrg_sum = sat_add32(r_co_a[0], r_co_b[0]);
    assign w_produce = !(w_both && (w_mrg_sum[SUM_W-1:0] == '0));

    always_comb begin
        if (w_take_a) begin
            w_term_co = r_co_a[0];
            w_term_ex = r_ex_a[0];
            w_term_st = STAT_OK;
        end else if (w_take_b) begin
            w_term_co = r_co_b[0];
            w_term_ex = r_ex_b[0];
            w_term_st = STAT_OK;
        end else begin
            w_term_co = w_mrg_sum[SUM_W-1:0];
            w_term_ex = r_ex_a[0];
            w_term_st = w_mrg_sum[SUM_W] ? STAT_SAT : STAT_OK;
        end
    end

    always_comb begin
        n_ex_a  = r_ex_a;
        n_co_a  = r_co_a;
        n_cnt_a = r_cnt_a;
        n_ex_b  = r_ex_b;
        n_co_b  = r_co_b;
        n_cnt_b = r_cnt_b;
        if (i_cmd.update && (w_found || !w_full)) begin
            if (r_sel) begin
                n_ex_b = w_ex_new;
                n_co_b = w_co_new;
                if (!w_found) begin
                    n_cnt_b = r_cnt_b + CW'(1);
                end
            end else begin
                n_ex_a = w_ex_new;
                n_co_a = w_co_new;
                if (!w_found) begin
                    n_cnt_a = r_cnt_a + CW'(1);
                end
            end
        end else if (i_cmd.step) begin
            if (w_take_a || w_both) begin
                n_ex_a  = w_ex_dn_a;
                n_co_a  = w_co_dn_a;
                n_cnt_a = r_cnt_a - CW'(1);
            end
            if (w_take_b || w_both) begin
                n_ex_b  = w_ex_dn_b;
                n_co_b  = w_co_dn_b;
                n_cnt_b = r_cnt_b - CW'(1);
            end
        end
    end

    assign w_out_free = !r_out_v || i_out_ready;
    assign w_wr_out   = i_cmd.update || i_cmd.flush ||
                        (i_cmd.step && w_produce && r_held_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            if (i_cmd.flush) begin
                r_held_v <= 1'b0;
            end else if (i_cmd.step && w_produce) begin
                r_held_v <= 1'b1;
            end
            if (w_wr_out) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex_a <= n_ex_a;
        r_co_a <= n_co_a;
        r_ex_b <= n_ex_b;
        r_co_b <= n_co_b;
        if (i_cmd.load) begin
            r_sel  <= (t_opcode'(i_opcode) == OP_INS_B);
            r_coef <= i_coefficient;
            r_exp  <= i_exponent;
        end
        if (i_cmd.compare) begin
            r_lt <= w_lt;
            r_eq <= w_eq;
        end
        if (i_cmd.step && w_produce) begin
            r_held_co <= w_term_co;
            r_held_ex <= w_term_ex;
            r_held_st <= w_term_st;
        end
        if (i_cmd.update) begin
            r_out_co    <= '0;
            r_out_ex    <= '0;
            r_out_last  <= 1'b1;
            r_out_empty <= 1'b0;
            r_out_st    <= w_ins_st;
        end else if (i_cmd.flush) begin
            r_out_co    <= r_held_v ? r_held_co : '0;
            r_out_ex    <= r_held_v ? r_held_ex : '0;
            r_out_last  <= 1'b1;
            r_out_empty <= !r_held_v;
            r_out_st    <= r_held_v ? r_held_st : STAT_OK;
        end else if (w_wr_out) begin
            r_out_co    <= r_held_co;
            r_out_ex    <= r_held_ex;
            r_out_last  <= 1'b0;
            r_out_empty <= 1'b0;
            r_out_st    <= r_held_st;
        end
    end

    assign o_stat.tables_empty   = !w_ha && !w_hb;
    assign o_stat.out_free       = w_out_free;
    assign o_stat.step_needs_out = w_produce && r_held_v;

    assign o_out_valid       = r_out_v;
    assign o_sum_coefficient = r_out_co;
    assign o_sum_exponent    = r_out_ex;
    assign o_last_term       = r_out_last;
    assign o_empty_sum       = r_out_empty;
    assign o_status          = r_out_st;

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_out |-> w_out_free)
        else $error("result register written while a result was still waiting");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CW'(MAX_TERMS)) && (r_cnt_b <= CW'(MAX_TERMS)))
        else $error("term count above table depth");

    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.compare |=> $onehot0(r_eq))
        else $error("exponent found in more than one table entry");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> !r_held_v && r_out_v && r_out_last)
        else $error("end of merge did not give a final result");

endmodule

// ----- hdl/spa_ctrl.sv -----
// Controller of the sparse polynomial adder: a one-hot state machine that
// sequences insert and merge work in the datapath. Depends on spa_pkg.
module spa_ctrl import spa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_opcode,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_stat   i_stat
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CMP   = 5'b00010,
        S_UPD   = 5'b00100,
        S_EMIT  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = w_accept;
                if (w_accept) begin
                    unique case (t_opcode'(i_opcode))
                        OP_INS_A, OP_INS_B: n_state = S_CMP;
                        OP_EMIT:            n_state = S_EMIT;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                if (i_stat.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_stat.tables_empty) begin
                    n_state = S_FLUSH;
                end else if (!i_stat.step_needs_out || i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/sparse_polynomial_adder.sv -----
// Sparse polynomial adder, top level: connects the controller and the datapath
// to the item and result channels. Depends on spa_pkg, spa_in_if, spa_out_if,
// spa_ctrl and spa_datapath.
//
// Usage: i_item carries one transaction per item (opcode, coefficient,
// exponent); o_result carries results. Opcodes 0 and 1 insert a term into
// table A or B; the status result is registered after the compare state and
// the update state, and the next item can be taken once the update is done.
// Opcode 2 merges both tables in ascending exponent order and streams the
// sum terms, the final one marked by last_term, then leaves both tables
// empty. One merge step is taken per cycle for each distinct exponent while
// the receiver keeps up. A single empty_sum result appears when nothing
// survives the merge. Opcode 3 is taken and ignored. One item is in work at
// a time: i_item.ready is high only between items, and the next item is
// taken while the previous result still waits in the output register. When
// the receiver stalls, the result register holds and the insert or the
// merge pauses until it is free.
// Synchronous reset empties both tables and drops any pending result.
module sparse_polynomial_adder import spa_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spa_in_if.sink     i_item,
    spa_out_if.source  o_result
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    spa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_opcode   (i_item.opcode),
        .o_in_ready (i_item.ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    spa_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_opcode          (i_item.opcode),
        .i_coefficient     (i_item.coefficient),
        .i_exponent        (i_item.exponent),
        .i_out_ready       (o_result.ready),
        .o_out_valid       (o_result.valid),
        .o_sum_coefficient (o_result.sum_coefficient),
        .o_sum_exponent    (o_result.sum_exponent),
        .o_last_term       (o_result.last_term),
        .o_empty_sum       (o_result.empty_sum),
        .o_status          (o_result.status)
    );

endmodule

// ----- verif/sparse_polynomial_adder_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sparse_polynomial_adder. It covers a directed table and
// random insert/emit bursts, all scored against a behavioural model.
// Depends on spa_pkg, spa_in_if, spa_out_if and the RTL of the adder.
module sparse_polynomial_adder_tb;
    import spa_pkg::*;

    localparam int TERMS        = MAX_TERMS_DEF;
    localparam int RANDOM_ITEMS = 200;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 2 * TERMS + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int TBL_A        = 0;
    localparam int TBL_B        = 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7fffffff;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh80000000;

    typedef struct {
        logic signed [SUM_W-1:0] coefficient;
        logic [EXP_W-1:0]        exponent;
        logic                    last;
        logic                    empty;
        logic [1:0]              status;
    } t_term_result;

    typedef enum {PREDICTED, TYPED_OK, TYPED_FULL, TYPED_EMPTY} t_typed;

    typedef struct {
        t_opcode                  op;
        logic signed [COEF_W-1:0] coefficient;
        logic [EXP_W-1:0]         exponent;
        t_typed                   typed;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    spa_in_if  item_ch ();
    spa_out_if result_ch ();

    sparse_polynomial_adder DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    always #5 i_clk = ~i_clk;

    // Model of the two term tables.
    logic [EXP_W-1:0]        tbl_exp  [2][TERMS];
    logic signed [SUM_W-1:0] tbl_coef [2][TERMS];
    int                      tbl_count[2];

    t_term_result expected_terms[$];
    t_stim_row    directed_rows[$];
    int           fail_count   = 0;
    bit           idling_on    = 1'b1;
    bit           hold_request = 1'b0;

    function automatic t_term_result make_result(input logic signed [SUM_W-1:0] c,
                                                 input logic [EXP_W-1:0] e,
                                                 input logic last, input logic empty,
                                                 input logic [1:0] st);
        t_term_result r;
        r.coefficient = c;
        r.exponent    = e;
        r.last        = last;
        r.empty       = empty;
        r.status      = st;
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] x,
                                                        input logic signed [SUM_W-1:0] y,
                                                        output bit saturated);
        longint total;
        total     = longint'(x) + longint'(y);
        saturated = 1'b1;
        if (total > longint'(SUM_MAX)) return SUM_MAX;
        if (total < longint'(SUM_MIN)) return SUM_MIN;
        saturated = 1'b0;
        return total[SUM_W-1:0];
    endfunction

    function automatic logic [1:0] insert_model(input int t,
                                                input logic signed [COEF_W-1:0] coef,
                                                input logic [EXP_W-1:0] expo);
        int                      n;
        int                      pos;
        int                      i;
        bit                      saturated;
        logic signed [SUM_W-1:0] wide;
        n    = tbl_count[t];
        pos  = 0;
        wide = coef;
        while (pos < n && tbl_exp[t][pos] < expo) pos++;
        // A present exponent is summed in even when the table is full.
        if (pos < n && tbl_exp[t][pos] == expo) begin
            tbl_coef[t][pos] = sat_sum(tbl_coef[t][pos], wide, saturated);
            return saturated ? STAT_SAT : STAT_OK;
        end
        if (n >= TERMS) return STAT_FULL;
        for (i = n; i > pos; i--) begin
            tbl_exp[t][i]  = tbl_exp[t][i-1];
            tbl_coef[t][i] = tbl_coef[t][i-1];
        end
        tbl_exp[t][pos]  = expo;
        tbl_coef[t][pos] = wide;
        tbl_count[t]     = n + 1;
        return STAT_OK;
    endfunction

    function automatic void merge_model();
        int                      ia;
        int                      ib;
        bit                      saturated;
        bit                      both;
        logic signed [SUM_W-1:0] c;
        logic [EXP_W-1:0]        e;
        t_term_result            terms[$];
        ia = 0;
        ib = 0;
        while (ia < tbl_count[TBL_A] || ib < tbl_count[TBL_B]) begin
            saturated = 1'b0;
            both      = 1'b0;
            if (ib >= tbl_count[TBL_B] ||
                (ia < tbl_count[TBL_A] && tbl_exp[TBL_A][ia] < tbl_exp[TBL_B][ib])) begin
                c = tbl_coef[TBL_A][ia];
                e = tbl_exp[TBL_A][ia];
                ia++;
            end else if (ia >= tbl_count[TBL_A] || tbl_exp[TBL_B][ib] < tbl_exp[TBL_A][ia]) begin
                c = tbl_coef[TBL_B][ib];
                e = tbl_exp[TBL_B][ib];
                ib++;
            end else begin
                c    = sat_sum(tbl_coef[TBL_A][ia], tbl_coef[TBL_B][ib], saturated);
                e    = tbl_exp[TBL_A][ia];
                both = 1'b1;
                ia++;
                ib++;
            end
            // Only a pair that cancels is dropped; a lone zero term passes through.
            if (!(both && c == 0)) begin
                terms.push_back(make_result(c, e, 1'b0, 1'b0, saturated ? STAT_SAT : STAT_OK));
            end
        end
        tbl_count[TBL_A] = 0;
        tbl_count[TBL_B] = 0;
        if (terms.size() == 0) begin
            expected_terms.push_back(make_result(0, 0, 1'b1, 1'b1, STAT_OK));
        end else begin
            terms[terms.size()-1].last = 1'b1;
            foreach (terms[k]) expected_terms.push_back(terms[k]);
        end
    endfunction

    function automatic void predict_item(input t_opcode op,
                                         input logic signed [COEF_W-1:0] coef,
                                         input logic [EXP_W-1:0] expo);
        case (op)
            OP_INS_A: begin
                expected_terms.push_back(make_result(0, 0, 1'b1, 1'b0,
                                                     insert_model(TBL_A, coef, expo)));
            end
            OP_INS_B: begin
                expected_terms.push_back(make_result(0, 0, 1'b1, 1'b0,
                                                     insert_model(TBL_B, coef, expo)));
            end
            OP_EMIT: begin
                merge_model();
            end
            default: ;
        endcase
    endfunction

    function automatic void add_row(input t_opcode op, input logic signed [COEF_W-1:0] coef,
                                    input logic [EXP_W-1:0] expo, input t_typed typed);
        t_stim_row row;
        row.op          = op;
        row.coefficient = coef;
        row.exponent    = expo;
        row.typed       = typed;
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string field, input longint want, input longint got);
        fail_count++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endtask

    // Called at a rising edge; returns at the edge where the transaction is accepted,
    // with valid still high so that a back-to-back item needs no second assignment.
    task automatic send_item(input t_opcode op, input logic signed [COEF_W-1:0] coef,
                             input logic [EXP_W-1:0] expo, input t_typed typed);
        int gap;
        gap = idling_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.opcode      <= op;
        item_ch.coefficient <= coef;
        item_ch.exponent    <= expo;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        predict_item(op, coef, expo);
        case (typed)
            TYPED_OK: begin
                expected_terms[expected_terms.size()-1] = make_result(0, 0, 1'b1, 1'b0, STAT_OK);
            end
            TYPED_FULL: begin
                expected_terms[expected_terms.size()-1] =
                    make_result(0, 0, 1'b1, 1'b0, STAT_FULL);
            end
            TYPED_EMPTY: begin
                expected_terms[expected_terms.size()-1] = make_result(0, 0, 1'b1, 1'b1, STAT_OK);
            end
            default: ;
        endcase
    endtask

    initial begin : result_sink
        int           stall;
        t_term_result want;
        t_term_result got;
        result_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                // Long hold-off so that the block fills up and stops taking items.
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = idling_on ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_ch.valid) @(posedge i_clk);
            got.coefficient = result_ch.sum_coefficient;
            got.exponent    = result_ch.sum_exponent;
            got.last        = result_ch.last_term;
            got.empty       = result_ch.empty_sum;
            got.status      = result_ch.status;
            if (expected_terms.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, coefficient %0d exponent %0d", $time,
                         got.coefficient, got.exponent);
            end else begin
                want = expected_terms.pop_front();
                if (got.coefficient !== want.coefficient) begin
                    report_mismatch("sum_coefficient", want.coefficient, got.coefficient);
                end
                if (got.exponent !== want.exponent) begin
                    report_mismatch("sum_exponent", want.exponent, got.exponent);
                end
                if (got.last !== want.last) begin
                    report_mismatch("last_term", want.last, got.last);
                end
                if (got.empty !== want.empty) begin
                    report_mismatch("empty_sum", want.empty, got.empty);
                end
                if (got.status !== want.status) begin
                    report_mismatch("status", want.status, got.status);
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("sparse_polynomial_adder_tb failed");
        $finish;
    end

    initial begin : stimulus
        int                       sent;
        int                       bursts;
        int                       burst_len;
        int                       split;
        int                       span;
        int                       pick;
        int                       k;
        t_opcode                  op;
        logic signed [COEF_W-1:0] coef;
        logic signed [COEF_W-1:0] prev_coef;
        logic [EXP_W-1:0]         expo;

        item_ch.valid       <= 1'b0;
        item_ch.opcode      <= OP_NONE;
        item_ch.coefficient <= '0;
        item_ch.exponent    <= '0;
        tbl_count[TBL_A]     = 0;
        tbl_count[TBL_B]     = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Table A is filled out of order so that inserts shift, then
        // overflowed, then merged against a few B terms.
        add_row(OP_EMIT,  16'sd0,      16'd0,     TYPED_EMPTY);
        add_row(OP_NONE,  16'sh5a5a,   16'ha5a5,  PREDICTED);
        add_row(OP_INS_A, 16'sh7fff,   16'd0,     TYPED_OK);
        add_row(OP_INS_A, 16'sh8000,   16'hffff,  TYPED_OK);
        add_row(OP_INS_A, 16'sd1200,   16'd40000, TYPED_OK);
        add_row(OP_INS_A, -16'sd3,     16'd30000, TYPED_OK);
        add_row(OP_INS_A, 16'sd77,     16'd20000, TYPED_OK);
        add_row(OP_INS_A, -16'sd4096,  16'd10000, TYPED_OK);
        add_row(OP_INS_A, 16'sd9,      16'd5000,  TYPED_OK);
        add_row(OP_INS_A, 16'sd31000,  16'd1000,  TYPED_OK);
        add_row(OP_INS_A, -16'sd1,     16'd500,   TYPED_OK);
        add_row(OP_INS_A, 16'sd256,    16'd100,   TYPED_OK);
        add_row(OP_INS_A, -16'sd20000, 16'd50,    TYPED_OK);
        add_row(OP_INS_A, 16'sd13,     16'd20,    TYPED_OK);
        add_row(OP_INS_A, 16'sd2,      16'd10,    TYPED_OK);
        add_row(OP_INS_A, -16'sd600,   16'd5,     TYPED_OK);
        add_row(OP_INS_A, 16'sd7,      16'd3,     TYPED_OK);
        add_row(OP_INS_A, 16'sd100,    16'd1,     TYPED_OK);
        add_row(OP_INS_A, 16'sd5,      16'd12345, TYPED_FULL);
        // The entry at exponent 3 drops to zero and stays in the table.
        add_row(OP_INS_A, -16'sd7,     16'd3,     TYPED_OK);
        add_row(OP_INS_B, -16'sd32767, 16'd0,     TYPED_OK);
        add_row(OP_INS_B, 16'sd1,      16'd2,     TYPED_OK);
        add_row(OP_EMIT,  16'sd0,      16'd0,     PREDICTED);
        // Every term cancels.
        add_row(OP_INS_B, 16'sd5,      16'd10,    TYPED_OK);
        add_row(OP_INS_A, -16'sd5,     16'd10,    TYPED_OK);
        add_row(OP_EMIT,  16'sd0,      16'd0,     TYPED_EMPTY);
        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].op, directed_rows[r].coefficient,
                      directed_rows[r].exponent, directed_rows[r].typed);
        end

        // Random bursts of inserts closed by an emit, with stray emits and unused
        // opcodes mixed in.
        hold_request = 1'b1;
        sent         = 0;
        bursts       = 0;
        prev_coef    = '0;
        while (sent < RANDOM_ITEMS) begin
            idling_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:       span = 4;
                1:       span = 16;
                2:       span = 40;
                default: span = 65536;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                burst_len = $urandom_range(17, 40);
                split     = 28;
            end else begin
                burst_len = $urandom_range(1, 12);
                split     = 17;
            end
            for (k = 0; k < burst_len; k++) begin
                pick = $urandom_range(0, 31);
                if (pick == 0) begin
                    op = OP_NONE;
                end else if (pick == 1) begin
                    op = OP_EMIT;
                end else if (pick < split) begin
                    op = OP_INS_A;
                end else begin
                    op = OP_INS_B;
                end
                case ($urandom_range(0, 7))
                    0:       coef = 16'sh7fff;
                    1:       coef = 16'sh8000;
                    2:       coef = -prev_coef;
                    default: coef = 16'($urandom);
                endcase
                if ($urandom_range(0, 15) == 0) begin
                    expo = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                end else begin
                    expo = 16'($urandom_range(0, span - 1));
                end
                prev_coef = coef;
                send_item(op, coef, expo, PREDICTED);
                if (op != OP_NONE) sent++;
            end
            send_item(OP_EMIT, 16'($urandom), 16'($urandom), PREDICTED);
            sent++;
            bursts++;
            if (bursts == 4) begin
                // Let the block run dry before the next burst.
                item_ch.valid <= 1'b0;
                wait (expected_terms.size() == 0);
                @(posedge i_clk);
            end
        end

        item_ch.valid <= 1'b0;
        wait (expected_terms.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_terms.size() != 0) begin
            fail_count++;
            $display("%0t: %0d expected results never arrived", $time, expected_terms.size());
        end
        if (fail_count == 0) begin
            $display("sparse_polynomial_adder_tb passed");
        end else begin
            $display("sparse_polynomial_adder_tb failed");
        end
        $finish;
    end

endmodule
